[sv/cc20_pkg.sv]
// shared types, constants and helpers for the chacha20 keystream generator
`timescale 1ns / 1ps

package cc20_pkg;

  // default number of double rounds (20-round cipher)
  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] blk_t;

  // sigma constants, state words 0..3
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646E;
  localparam word_t SIGMA2 = 32'h7962_2D32;
  localparam word_t SIGMA3 = 32'h6B20_6574;

  // bytes in one keystream block
  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  // configuration register indexes
  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;

  // quarter-round step codes
  localparam logic [1:0] QR_STEP_A16 = 2'd0;
  localparam logic [1:0] QR_STEP_C12 = 2'd1;
  localparam logic [1:0] QR_STEP_A8  = 2'd2;
  localparam logic [1:0] QR_STEP_C7  = 2'd3;

  // round engine status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  // rotate left by a constant amount
  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

[sv/cc20_core.sv]
// iterative round engine: four quarter-round lanes, one add-xor-rotate step a cycle
`timescale 1ns / 1ps

module cc20_core #(
  parameter int unsigned DoubleRounds = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cc20_pkg::blk_t      init_i,
  output cc20_pkg::core_sts_t sts_o,
  output cc20_pkg::blk_t      x_o
);

  localparam int unsigned Rounds = 2 * DoubleRounds;
  localparam int unsigned RndW   = $clog2(Rounds);
  localparam logic [RndW-1:0] LastRnd = RndW'(Rounds - 1);

  cc20_pkg::blk_t    x_q, x_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [1:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic              done;
  logic [3:0]        ia [4];
  logic [3:0]        ib [4];
  logic [3:0]        ic [4];
  logic [3:0]        id [4];
  cc20_pkg::word_t   sum [4];

  // lane word selection: even rounds columns, odd rounds diagonals
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ia[l] = 4'(l);
      ib[l] = {2'b01, 2'(l + (rnd_q[0] ? 1 : 0))};
      ic[l] = {2'b10, 2'(l + (rnd_q[0] ? 2 : 0))};
      id[l] = {2'b11, 2'(l + (rnd_q[0] ? 3 : 0))};
    end
  end

  // one quarter-round step in each lane
  always_comb begin
    x_d = x_q;
    for (int l = 0; l < 4; l++) begin
      sum[l] = '0;
      unique case (step_q)
        cc20_pkg::QR_STEP_A16: begin
          sum[l]     = x_q[ia[l]] + x_q[ib[l]];
          x_d[ia[l]] = sum[l];
          x_d[id[l]] = cc20_pkg::rotl(x_q[id[l]] ^ sum[l], 16);
        end
        cc20_pkg::QR_STEP_C12: begin
          sum[l]     = x_q[ic[l]] + x_q[id[l]];
          x_d[ic[l]] = sum[l];
          x_d[ib[l]] = cc20_pkg::rotl(x_q[ib[l]] ^ sum[l], 12);
        end
        cc20_pkg::QR_STEP_A8: begin
          sum[l]     = x_q[ia[l]] + x_q[ib[l]];
          x_d[ia[l]] = sum[l];
          x_d[id[l]] = cc20_pkg::rotl(x_q[id[l]] ^ sum[l], 8);
        end
        cc20_pkg::QR_STEP_C7: begin
          sum[l]     = x_q[ic[l]] + x_q[id[l]];
          x_d[ic[l]] = sum[l];
          x_d[ib[l]] = cc20_pkg::rotl(x_q[ib[l]] ^ sum[l], 7);
        end
        default: ;
      endcase
    end
  end

  assign done = busy_q && (rnd_q == LastRnd) && (step_q == cc20_pkg::QR_STEP_C7);

  // round and step sequencing
  always_comb begin
    rnd_d  = rnd_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rnd_d  = '0;
      step_d = cc20_pkg::QR_STEP_A16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      if (step_q == cc20_pkg::QR_STEP_C7) begin
        rnd_d = rnd_q + RndW'(1);
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      step_q <= cc20_pkg::QR_STEP_A16;
      busy_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  // working state, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= init_i;
    end else if (busy_q) begin
      x_q <= x_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done;
  assign x_o        = x_q;

endmodule

[sv/chacha20_keystream_generator.sv]
// top level: request sequencing, keystream buffer memory and configuration
//
// A request on the s_axis channel carries a restart flag and a byte count
// (0..64, larger values are treated as 64). The block answers with that many
// keystream bytes on m_axis, least significant byte of each state word first,
// with m_axis_tlast on the final byte; a count of zero yields no bytes.
// Restart zeroes the block counter and empties the buffer before any byte.
// Key and nonce are to be written through the cfg port only while the block
// is idle; the block itself does not enforce this. They apply from the next
// block computed. The 64-byte buffer sits in a 16x32 memory with a registered
// read. Each byte passes through a memory read, then the output register. When
// the buffer is empty a refill launches the round engine (four lanes, one step
// a cycle), then adds the input words to its result and writes the memory.
// A new request is taken only once the previous one has been fully issued
// into the output register. A stalled receiver holds the output register
// and the sequencer waits. After reset the counter is zero, the buffer is
// empty, key and nonce are zero; no clearing pass is run.
`timescale 1ns / 1ps

module chacha20_keystream_generator #(
  parameter int unsigned DoubleRounds = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart_stream, [7:1] byte_count
  // keystream channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] keystream_byte
  output logic        m_axis_tlast,   // last_byte
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NEXT   = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_ROUNDS = 3'd3;
  localparam logic [2:0] ST_STORE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [6:0]          pos_q, pos_d;
  logic [6:0]          rem_q, rem_d;
  logic [31:0]         blk_cnt_q, blk_cnt_d;
  logic [3:0]          widx_q, widx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  logic                out_load;
  logic [31:0]         key_q [8];
  logic [31:0]         nonce_q [3];
  cc20_pkg::blk_t      init_w;
  cc20_pkg::blk_t      x_w;
  cc20_pkg::core_sts_t core_sts;
  logic                core_start;
  logic                req_accept;
  logic [6:0]          req_count;
  logic                mem_we;
  logic                mem_re;
  logic [31:0]         mem_wdata;
  logic [31:0]         mem [16];
  logic [31:0]         rdata_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) key_q[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cc20_pkg::REG_KEY01: begin
          key_q[0] <= cfg_wdata_i[31:0];
          key_q[1] <= cfg_wdata_i[63:32];
        end
        cc20_pkg::REG_KEY23: begin
          key_q[2] <= cfg_wdata_i[31:0];
          key_q[3] <= cfg_wdata_i[63:32];
        end
        cc20_pkg::REG_KEY45: begin
          key_q[4] <= cfg_wdata_i[31:0];
          key_q[5] <= cfg_wdata_i[63:32];
        end
        cc20_pkg::REG_KEY67: begin
          key_q[6] <= cfg_wdata_i[31:0];
          key_q[7] <= cfg_wdata_i[63:32];
        end
        cc20_pkg::REG_NONCE01: begin
          nonce_q[0] <= cfg_wdata_i[31:0];
          nonce_q[1] <= cfg_wdata_i[63:32];
        end
        cc20_pkg::REG_NONCE2: begin
          nonce_q[2] <= cfg_wdata_i[31:0];
        end
        default: ;
      endcase
    end
  end

  // block input words
  always_comb begin
    init_w[0]  = cc20_pkg::SIGMA0;
    init_w[1]  = cc20_pkg::SIGMA1;
    init_w[2]  = cc20_pkg::SIGMA2;
    init_w[3]  = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init_w[4 + i] = key_q[i];
    init_w[12] = blk_cnt_q;
    init_w[13] = nonce_q[0];
    init_w[14] = nonce_q[1];
    init_w[15] = nonce_q[2];
  end

  cc20_core #(
    .DoubleRounds(DoubleRounds)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(core_start),
    .init_i (init_w),
    .sts_o  (core_sts),
    .x_o    (x_w)
  );

  // request handshake and saturated count
  assign s_axis_tready = (state_q == ST_IDLE);
  assign req_accept    = s_axis_tvalid && s_axis_tready;
  assign req_count     = s_axis_tdata[7] ? cc20_pkg::BLOCK_BYTES : s_axis_tdata[7:1];
  assign out_load      = (state_q == ST_FETCH) && (!out_valid_q || m_axis_tready);
  assign core_start    = (state_q == ST_NEXT) && pos_q[6];
  assign mem_re        = (state_q == ST_NEXT) && !pos_q[6];
  assign mem_we        = (state_q == ST_STORE);
  assign mem_wdata     = x_w[widx_q] + init_w[widx_q];

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    blk_cnt_d   = blk_cnt_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          if (s_axis_tdata[0]) begin
            blk_cnt_d = '0;
            pos_d     = cc20_pkg::BLOCK_BYTES;
          end
          rem_d = req_count;
          if (req_count != 7'd0) begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        state_d = pos_q[6] ? ST_ROUNDS : ST_FETCH;
      end
      ST_FETCH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          pos_d       = pos_q + 7'd1;
          rem_d       = rem_q - 7'd1;
          state_d     = (rem_q == 7'd1) ? ST_IDLE : ST_NEXT;
        end
      end
      ST_ROUNDS: begin
        if (core_sts.done) begin
          widx_d  = '0;
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        widx_d = widx_q + 4'd1;
        if (widx_q == 4'd15) begin
          blk_cnt_d = blk_cnt_q + 32'd1;
          pos_d     = '0;
          state_d   = ST_NEXT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= cc20_pkg::BLOCK_BYTES;
      rem_q       <= '0;
      blk_cnt_q   <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      blk_cnt_q   <= blk_cnt_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= 8'(rdata_q >> {pos_q[1:0], 3'b000});
      out_last_q <= (rem_q == 7'd1);
    end
  end

  // keystream buffer memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[widx_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[pos_q[5:2]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // byte position never runs past an empty buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= cc20_pkg::BLOCK_BYTES)
    else $error("byte position beyond block");

  // writeback only after the round engine has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |-> !core_sts.busy)
    else $error("buffer written while rounds still running");

  // an empty buffer always launches the round engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXT && pos_q[6]) |=> (core_sts.busy && state_q == ST_ROUNDS))
    else $error("refill not started");

  // a new byte appears only out of the fetch state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FETCH))
    else $error("byte issued outside fetch");

endmodule

[bench/testbench.sv]
// self-checking testbench for the chacha20 keystream generator
`timescale 1ns / 1ps

module testbench;

  localparam int DBL_ROUNDS   = cc20_pkg::DOUBLE_ROUNDS_DEF;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE       = 200;   // idle gap between phases
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 52;

  // register indexes outside the map, writes there are dropped
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  // quarter-round lanes: four columns, then four diagonals
  localparam int QR_LANE [8][4] = '{
    '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
  };

  typedef struct packed {
    logic       restart;
    logic [6:0] count;
  } ks_request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ks_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] restart_stream, [7:1] byte_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] keystream_byte
  logic        m_axis_tlast;        // last_byte
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  // predictor state: configuration, counter and current block
  cc20_pkg::word_t key_w [8];
  cc20_pkg::word_t nonce_w [3];
  cc20_pkg::word_t blk_ctr;
  cc20_pkg::blk_t  ks_words;
  int              buf_pos;

  ks_request_t pending [$];
  ks_byte_t    keystream_due [$];
  int unsigned mismatches = 0;
  logic        req_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned quiet_cycles = 0;

  chacha20_keystream_generator #(
    .DoubleRounds(DBL_ROUNDS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one quarter round on four words, returned as {a, b, c, d}
  function automatic logic [127:0] quarter(input cc20_pkg::word_t a, input cc20_pkg::word_t b,
                                           input cc20_pkg::word_t c, input cc20_pkg::word_t d);
    a += b; d ^= a; d = {d[15:0], d[31:16]};
    c += d; b ^= c; b = {b[19:0], b[31:20]};
    a += b; d ^= a; d = {d[23:0], d[31:24]};
    c += d; b ^= c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

  // full block for a given counter with the current key and nonce
  function automatic cc20_pkg::blk_t chacha_block(input cc20_pkg::word_t ctr);
    cc20_pkg::word_t init [16];
    cc20_pkg::word_t x [16];
    cc20_pkg::blk_t  res;
    int              a, b, c, d;
    init[0] = cc20_pkg::SIGMA0;
    init[1] = cc20_pkg::SIGMA1;
    init[2] = cc20_pkg::SIGMA2;
    init[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
    init[12] = ctr;
    for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
    x = init;
    for (int r = 0; r < DBL_ROUNDS; r++) begin
      for (int q = 0; q < 8; q++) begin
        a = QR_LANE[q][0];
        b = QR_LANE[q][1];
        c = QR_LANE[q][2];
        d = QR_LANE[q][3];
        {x[a], x[b], x[c], x[d]} = quarter(x[a], x[b], x[c], x[d]);
      end
    end
    for (int i = 0; i < 16; i++) res[i] = x[i] + init[i];
    return res;
  endfunction

  // expected keystream bytes for one accepted request
  function automatic void predict_keystream(input logic restart, input logic [6:0] cnt);
    int       n;
    ks_byte_t e;
    n = (cnt > cc20_pkg::BLOCK_BYTES) ? int'(cc20_pkg::BLOCK_BYTES) : int'(cnt);
    if (restart) begin
      blk_ctr = '0;
      buf_pos = cc20_pkg::BLOCK_BYTES;
    end
    for (int k = 0; k < n; k++) begin
      if (buf_pos >= cc20_pkg::BLOCK_BYTES) begin
        ks_words = chacha_block(blk_ctr);
        blk_ctr  = blk_ctr + 32'd1;
        buf_pos  = 0;
      end
      e.data = ks_words[buf_pos / 4][8 * (buf_pos % 4) +: 8];
      e.last = (k == n - 1);
      keystream_due.push_back(e);
      buf_pos++;
    end
  endfunction

  // request driver, bursts with random gaps
  always @(negedge clk_i) begin : request_driver
    ks_request_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        item = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {item.count, item.restart};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // keystream receiver, stall pattern by cycle window plus long hold-offs
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 173) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (rx_cycle % 6 == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: check keystream bytes, predict on accepted requests
  always @(posedge clk_i) begin : monitor
    ks_byte_t want;
    req_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (keystream_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = keystream_due.pop_front();
        if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_keystream(s_axis_tdata[0], s_axis_tdata[7:1]);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("chacha20_keystream_generator verification failed");
      $finish;
    end
  end

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      cc20_pkg::REG_KEY01, cc20_pkg::REG_KEY23,
      cc20_pkg::REG_KEY45, cc20_pkg::REG_KEY67: begin
        key_w[2 * idx]     = val[31:0];
        key_w[2 * idx + 1] = val[63:32];
      end
      cc20_pkg::REG_NONCE01: begin
        nonce_w[0] = val[31:0];
        nonce_w[1] = val[63:32];
      end
      cc20_pkg::REG_NONCE2: nonce_w[2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_request(input logic restart, input logic [6:0] cnt);
    ks_request_t r;
    r.restart = restart;
    r.count   = cnt;
    pending.push_back(r);
  endtask

  // wait for all requests and bytes, sampled once the driver outputs have settled
  task automatic wait_drained();
    while (pending.size() != 0 || s_axis_tvalid || keystream_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mostly well-formed requests, some empty, oversized and restarting
  task automatic queue_random(input int n);
    logic [6:0] cnt;
    int         sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0)      cnt = 7'd0;
      else if (sel == 1) cnt = 7'($urandom_range(65, 127));
      else if (sel == 2) cnt = cc20_pkg::BLOCK_BYTES;
      else               cnt = 7'($urandom_range(1, 64));
      push_request($urandom_range(0, 7) == 0, cnt);
    end
  endtask

  function automatic logic [63:0] random_value();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) key_w[i] = '0;
    for (int i = 0; i < 3; i++) nonce_w[i] = '0;
    blk_ctr  = '0;
    ks_words = '0;
    buf_pos  = cc20_pkg::BLOCK_BYTES;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero key: single byte, empty, oversized, restarts with and without bytes
    push_request(1'b0, 7'd1);
    push_request(1'b0, 7'd0);
    push_request(1'b0, 7'd63);
    push_request(1'b0, 7'd127);
    push_request(1'b0, 7'd64);
    push_request(1'b1, 7'd0);
    push_request(1'b0, 7'd2);
    push_request(1'b1, 7'd65);
    push_request(1'b1, 7'd5);
    push_request(1'b0, 7'd30);
    wait_drained();

    // all ones everywhere, spare indexes ignored, buffer left half used
    write_reg(cc20_pkg::REG_KEY01, '1);
    write_reg(cc20_pkg::REG_KEY23, '1);
    write_reg(cc20_pkg::REG_KEY45, '1);
    write_reg(cc20_pkg::REG_KEY67, '1);
    write_reg(cc20_pkg::REG_NONCE01, '1);
    write_reg(cc20_pkg::REG_NONCE2, '1);
    write_reg(REG_SPARE6, {$urandom, $urandom});
    write_reg(REG_SPARE7, '1);
    close_writes();
    push_request(1'b0, 7'd40);
    push_request(1'b0, 7'd64);
    push_request(1'b1, 7'd64);
    push_request(1'b1, 7'd64);
    wait_drained();

    // fresh random key mid-stream
    write_reg(cc20_pkg::REG_KEY01, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_KEY23, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_KEY45, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_KEY67, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_NONCE01, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_NONCE2, {32'h0, $urandom});
    close_writes();
    push_request(1'b0, 7'd17);
    push_request(1'b0, 7'd64);
    push_request(1'b1, 7'd3);
    wait_drained();

    // random phases, the second one with a long receiver hold-off
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) begin
        for (int r = 0; r < 6; r++) write_reg(r[2:0], '0);
      end else begin
        for (int w = $urandom_range(1, 4); w > 0; w--)
          write_reg(3'($urandom_range(0, 7)), random_value());
      end
      close_writes();
      queue_random(PHASE_ITEMS);
      if (p == 1) hold_asked++;
      wait_drained();
    end

    if (keystream_due.size() != 0) begin
      mismatches += keystream_due.size();
      $display("%0d expected bytes never arrived", keystream_due.size());
    end
    if (mismatches == 0)
      $display("chacha20_keystream_generator verification clean");
    else
      $display("chacha20_keystream_generator verification failed");
    $finish;
  end

endmodule
